// ===== hw/rtl/fpcs_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpcs_pkg
// Shared types and constants of the fan PWM calibration sequencer.
// ---------------------------------------------------------------------------
package fpcs_pkg;

    localparam int WINDOW_MAX = 16;
    localparam int WIN_IDX_W  = $clog2(WINDOW_MAX);
    localparam int WIN_LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int SPEED_W    = 16;
    localparam int TEMP_W     = 18;
    localparam int PWM_W      = 8;
    localparam int SSUM_W     = SPEED_W + WIN_IDX_W;
    localparam int TSUM_W     = TEMP_W + WIN_IDX_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_FLOOR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_CEIL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION  = 3'd4;

    // Operation codes of an input transaction.
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DOWN     = 3'd1,
        PH_SETTLE   = 3'd2,
        PH_UP       = 3'd3,
        PH_VALIDATE = 3'd4,
        PH_DONE     = 3'd5,
        PH_ERROR    = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERTEMP = 2'd1,
        ERR_NO_START = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHKS,
        S_CHKT,
        S_DIVS,
        S_DIVT,
        S_OUT
    } fsm_t;

endpackage

// ===== hw/rtl/fpcs_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpcs_div
// Restoring divider, one quotient bit per cycle, for the window means.
// ---------------------------------------------------------------------------
module fpcs_div
    import fpcs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [TSUM_W-1:0]    dividend,
    input  logic [WIN_LEN_W-1:0] divisor,
    output logic                 done,
    output logic [TSUM_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(TSUM_W + 1);

    logic [TSUM_W-1:0]    quo_reg;
    logic [WIN_LEN_W:0]   rem_reg;
    logic [WIN_LEN_W-1:0] dsr_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [WIN_LEN_W:0]   trial;

    // Shift in the next dividend bit and try a subtraction.
    assign trial = {rem_reg[WIN_LEN_W-1:0], quo_reg[TSUM_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(TSUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_reg <= trial - {1'b0, dsr_reg};
                quo_reg <= {quo_reg[TSUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[TSUM_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/fan_pwm_calibration_sequencer_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fan_pwm_calibration_sequencer_core
// Finds the stop and start PWM levels of a fan from speed/temperature ticks.
// ---------------------------------------------------------------------------
// Usage: the input channel (s_) carries a start command (op 0) or a sample
// tick (op 1) with one fan speed and one temperature reading. Every input
// transaction yields exactly one result transaction on the m_ channel with
// the PWM to apply, the phase, the error code and the calibration results.
// Configuration registers are written through cfg_wr_en/cfg_index/
// cfg_wr_data and take effect at once; write them only while idle.
// Flow: a transaction that needs no window scan passes through S_OUT and
// reaches the result register once that register is free; s_ready returns
// when the sequencer is back in S_IDLE. A tick in the downward sweep that is
// not aborted scans the window once (one entry per cycle), runs two stability
// checks on a shared multiplier and, when stable, two means on a shared
// bit-serial divider. One item is processed at a time; s_ready is high only
// when the block is idle. A result waits in the output register while
// m_ready is low; one further item is accepted and processed meanwhile, and
// its result then waits for the register. Reset clears the calibration state,
// loads the register defaults and leaves both channels empty.
// ---------------------------------------------------------------------------
module fan_pwm_calibration_sequencer_core
    import fpcs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [SPEED_W-1:0]    s_fan_speed,
    input  logic [TEMP_W-1:0]     s_temperature,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PWM_W-1:0]      m_pwm_drive,
    output logic [2:0]            m_phase,
    output logic [1:0]            m_error_code,
    output logic                  m_finished,
    output logic [PWM_W:0]        m_stop_pwm,
    output logic [PWM_W-1:0]      m_start_pwm,
    output logic [SPEED_W-1:0]    m_slowest_speed,
    output logic [TEMP_W-1:0]     m_slowest_temp
);

    // Configuration registers.
    logic [TEMP_W-1:0]    temp_limit_reg;
    logic [PWM_W-1:0]     pwm_floor_reg;
    logic [PWM_W-1:0]     pwm_ceil_reg;
    logic [4:0]           win_len_reg;
    logic [15:0]          precision_reg;

    // Calibration state.
    phase_t               phase_reg;
    err_t                 error_reg;
    logic [PWM_W:0]       pwm_level_reg;
    logic [SPEED_W-1:0]   swin_reg [WINDOW_MAX];
    logic [TEMP_W-1:0]    twin_reg [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] wvalid_reg;
    logic [WIN_IDX_W-1:0] wptr_reg;
    logic [4:0]           run_cnt_reg;
    logic                 recorded_reg;
    logic [SPEED_W-1:0]   mean_s_reg;
    logic [TEMP_W-1:0]    mean_t_reg;
    logic [PWM_W:0]       stop_pwm_reg;
    logic [PWM_W-1:0]     start_pwm_reg;
    logic [SPEED_W-1:0]   slow_s_reg;
    logic [TEMP_W-1:0]    slow_t_reg;
    logic [SPEED_W-1:0]   spd_reg;
    logic [TEMP_W-1:0]    tmp_reg;

    // Scan and check datapath.
    fsm_t                 fsm_reg;
    fsm_t                 fsm_next;
    logic [WIN_IDX_W-1:0] idx_reg;
    logic [SPEED_W-1:0]   smin_reg, smax_reg;
    logic [TEMP_W-1:0]    tmin_reg, tmax_reg;
    logic [SSUM_W-1:0]    ssum_reg;
    logic [TSUM_W-1:0]    tsum_reg;
    logic                 sstab_reg;
    logic [SPEED_W-1:0]   new_mean_s_reg;
    logic                 m_valid_reg;

    logic [WIN_LEN_W-1:0] n_len;
    logic                 accept;
    logic                 scan_last;
    logic [SPEED_W-1:0]   rd_s;
    logic [TEMP_W-1:0]    rd_t;
    logic [TEMP_W-1:0]    chk_lo;
    logic [TEMP_W-1:0]    chk_hi;
    logic [33:0]          chk_prod;
    logic                 chk_ok;
    logic                 div_start;
    logic [TSUM_W-1:0]    div_dividend;
    logic                 div_done;
    logic [TSUM_W-1:0]    div_quo;
    logic                 out_free;
    logic [WIN_IDX_W-1:0] wp;
    logic [PWM_W-1:0]     dec_level;
    logic [PWM_W:0]       inc_level;
    logic [PWM_W-1:0]     drive;

    // Effective window length, clamped to 1..WINDOW_MAX.
    always_comb begin
        if (win_len_reg == '0) begin
            n_len = WIN_LEN_W'(1);
        end else if ({1'b0, win_len_reg} > 6'(WINDOW_MAX)) begin
            n_len = WIN_LEN_W'(WINDOW_MAX);
        end else begin
            n_len = WIN_LEN_W'(win_len_reg);
        end
    end

    assign accept    = s_valid && s_ready;
    assign s_ready   = (fsm_reg == S_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign scan_last = ({1'b0, idx_reg} == n_len - 1'b1);
    assign wp        = ({1'b0, wptr_reg} >= n_len) ? '0 : wptr_reg;
    assign dec_level = pwm_level_reg[PWM_W-1:0] - 1'b1;
    assign inc_level = pwm_level_reg + 1'b1;

    // Window read port: an entry cleared since the last level reads as zero.
    assign rd_s = wvalid_reg[idx_reg] ? swin_reg[idx_reg] : '0;
    assign rd_t = wvalid_reg[idx_reg] ? twin_reg[idx_reg] : '0;

    // Shared stability check: min nonzero and (max - min) * 65536 < precision * min.
    always_comb begin
        if (fsm_reg == S_CHKS) begin
            chk_lo = TEMP_W'(smin_reg);
            chk_hi = TEMP_W'(smax_reg);
        end else begin
            chk_lo = tmin_reg;
            chk_hi = tmax_reg;
        end
        chk_prod = 34'(precision_reg) * 34'(chk_lo);
        chk_ok   = (chk_lo != '0) && ({chk_hi - chk_lo, 16'h0000} < chk_prod);
    end

    // Shared divider for both means.
    assign div_start    = ((fsm_reg == S_CHKT) && chk_ok && sstab_reg)
                          || ((fsm_reg == S_DIVS) && div_done);
    assign div_dividend = (fsm_reg == S_CHKT) ? TSUM_W'(ssum_reg) : tsum_reg;

    fpcs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (n_len),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Sequencer next state.
    always_comb begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_op == OP_TICK && phase_reg == PH_DOWN
                        && s_temperature < temp_limit_reg && s_fan_speed != '0) begin
                        fsm_next = S_SCAN;
                    end else begin
                        fsm_next = S_OUT;
                    end
                end
            end
            S_SCAN:  if (scan_last) fsm_next = S_CHKS;
            S_CHKS:  fsm_next = S_CHKT;
            S_CHKT:  fsm_next = (chk_ok && sstab_reg) ? S_DIVS : S_OUT;
            S_DIVS:  if (div_done) fsm_next = S_DIVT;
            S_DIVT:  if (div_done) fsm_next = S_OUT;
            S_OUT:   if (out_free) fsm_next = S_IDLE;
            default: fsm_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg <= S_IDLE;
        end else begin
            fsm_reg <= fsm_next;
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_limit_reg <= TEMP_W'(85000);
            pwm_floor_reg  <= '0;
            pwm_ceil_reg   <= 8'd255;
            win_len_reg    <= 5'd15;
            precision_reg  <= 16'd983;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TEMP_LIMIT: temp_limit_reg <= cfg_wr_data;
                CFG_PWM_FLOOR:  pwm_floor_reg  <= cfg_wr_data[PWM_W-1:0];
                CFG_PWM_CEIL:   pwm_ceil_reg   <= cfg_wr_data[PWM_W-1:0];
                CFG_WIN_LEN:    win_len_reg    <= cfg_wr_data[4:0];
                CFG_PRECISION:  precision_reg  <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    // Window sample storage.
    always_ff @(posedge aclk) begin
        if (accept && s_op == OP_TICK && phase_reg == PH_DOWN) begin
            swin_reg[wp] <= s_fan_speed;
            twin_reg[wp] <= s_temperature;
        end
    end

    // Scan accumulators: min, max and sum of both windows.
    always_ff @(posedge aclk) begin
        if (fsm_reg == S_IDLE) begin
            idx_reg <= '0;
        end else if (fsm_reg == S_SCAN) begin
            idx_reg <= idx_reg + 1'b1;
            if (idx_reg == '0) begin
                smin_reg <= rd_s;
                smax_reg <= rd_s;
                tmin_reg <= rd_t;
                tmax_reg <= rd_t;
                ssum_reg <= SSUM_W'(rd_s);
                tsum_reg <= TSUM_W'(rd_t);
            end else begin
                if (rd_s < smin_reg) smin_reg <= rd_s;
                if (rd_s > smax_reg) smax_reg <= rd_s;
                if (rd_t < tmin_reg) tmin_reg <= rd_t;
                if (rd_t > tmax_reg) tmax_reg <= rd_t;
                ssum_reg <= ssum_reg + SSUM_W'(rd_s);
                tsum_reg <= tsum_reg + TSUM_W'(rd_t);
            end
        end
        if (fsm_reg == S_CHKS) begin
            sstab_reg <= chk_ok;
        end
        if (fsm_reg == S_DIVS && div_done) begin
            new_mean_s_reg <= div_quo[SPEED_W-1:0];
        end
    end

    // Calibration state updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            error_reg     <= ERR_NONE;
            pwm_level_reg <= '0;
            wvalid_reg    <= '0;
            wptr_reg      <= '0;
            run_cnt_reg   <= '0;
            recorded_reg  <= 1'b0;
            mean_s_reg    <= '0;
            mean_t_reg    <= '0;
            stop_pwm_reg  <= '0;
            start_pwm_reg <= '0;
            slow_s_reg    <= '0;
            slow_t_reg    <= '0;
            spd_reg       <= '0;
            tmp_reg       <= '0;
        end else if (accept) begin
            spd_reg <= s_fan_speed;
            tmp_reg <= s_temperature;
            if (s_op == OP_START) begin
                // Restart: clear the results and sweep down, or settle at once if ceil <= floor.
                wvalid_reg    <= '0;
                wptr_reg      <= '0;
                run_cnt_reg   <= '0;
                recorded_reg  <= 1'b0;
                mean_s_reg    <= '0;
                mean_t_reg    <= '0;
                start_pwm_reg <= '0;
                error_reg     <= ERR_NONE;
                pwm_level_reg <= {1'b0, pwm_ceil_reg};
                if (pwm_ceil_reg > pwm_floor_reg) begin
                    phase_reg    <= PH_DOWN;
                    stop_pwm_reg <= '0;
                    slow_s_reg   <= '0;
                    slow_t_reg   <= '0;
                end else begin
                    stop_pwm_reg <= {1'b0, pwm_floor_reg} + 1'b1;
                    slow_s_reg   <= s_fan_speed;
                    slow_t_reg   <= s_temperature;
                    phase_reg    <= PH_SETTLE;
                end
            end else begin
                unique case (phase_reg)
                    PH_DOWN: begin
                        wvalid_reg[wp] <= 1'b1;
                        wptr_reg <= ({1'b0, wp} + 1'b1 >= n_len) ? '0 : wp + 1'b1;
                        if (s_temperature >= temp_limit_reg) begin
                            error_reg <= ERR_OVERTEMP;
                            phase_reg <= PH_ERROR;
                        end else if (s_fan_speed == '0) begin
                            stop_pwm_reg <= inc_level;
                            slow_s_reg   <= recorded_reg ? mean_s_reg : s_fan_speed;
                            slow_t_reg   <= recorded_reg ? mean_t_reg : s_temperature;
                            phase_reg    <= PH_SETTLE;
                        end
                    end
                    PH_SETTLE: begin
                        if (stop_pwm_reg < {1'b0, pwm_ceil_reg}) begin
                            pwm_level_reg <= stop_pwm_reg;
                            phase_reg     <= PH_UP;
                        end else begin
                            error_reg <= ERR_NO_START;
                            phase_reg <= PH_ERROR;
                        end
                    end
                    PH_UP: begin
                        if (s_temperature >= temp_limit_reg) begin
                            error_reg <= ERR_OVERTEMP;
                            phase_reg <= PH_ERROR;
                        end else if (s_fan_speed != '0) begin
                            run_cnt_reg <= '0;
                            phase_reg   <= PH_VALIDATE;
                        end else begin
                            pwm_level_reg <= inc_level;
                            if (inc_level >= {1'b0, pwm_ceil_reg}) begin
                                error_reg <= ERR_NO_START;
                                phase_reg <= PH_ERROR;
                            end
                        end
                    end
                    PH_VALIDATE: begin
                        if (s_fan_speed == '0) begin
                            pwm_level_reg <= inc_level;
                            if (inc_level >= {1'b0, pwm_ceil_reg}) begin
                                error_reg <= ERR_NO_START;
                                phase_reg <= PH_ERROR;
                            end else begin
                                phase_reg <= PH_UP;
                            end
                        end else begin
                            run_cnt_reg <= run_cnt_reg + 1'b1;
                            if (6'(run_cnt_reg) + 6'd1 >= 6'(n_len)) begin
                                start_pwm_reg <= pwm_level_reg[PWM_W-1:0];
                                phase_reg     <= PH_DONE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end else if (fsm_reg == S_DIVT && div_done) begin
            // Stable level: record means, clear the window and step down (settle at the floor).
            mean_s_reg    <= new_mean_s_reg;
            mean_t_reg    <= div_quo[TEMP_W-1:0];
            recorded_reg  <= 1'b1;
            wvalid_reg    <= '0;
            wptr_reg      <= '0;
            pwm_level_reg <= {1'b0, dec_level};
            if (dec_level <= pwm_floor_reg) begin
                stop_pwm_reg <= {1'b0, pwm_floor_reg} + 1'b1;
                slow_s_reg   <= spd_reg;
                slow_t_reg   <= tmp_reg;
                phase_reg    <= PH_SETTLE;
            end
        end
    end

    // PWM drive for the current phase.
    always_comb begin
        unique case (phase_reg)
            PH_DOWN, PH_UP:        drive = pwm_level_reg[PWM_W-1:0];
            PH_VALIDATE, PH_DONE:  drive = stop_pwm_reg[PWM_W-1:0];
            PH_ERROR:              drive = pwm_ceil_reg;
            default:               drive = '0;
        endcase
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fsm_reg == S_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fsm_reg == S_OUT && out_free) begin
            m_pwm_drive     <= drive;
            m_phase         <= phase_reg;
            m_error_code    <= error_reg;
            m_finished      <= (phase_reg == PH_DONE) || (phase_reg == PH_ERROR);
            m_stop_pwm      <= stop_pwm_reg;
            m_start_pwm     <= start_pwm_reg;
            m_slowest_speed <= slow_s_reg;
            m_slowest_temp  <= slow_t_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fan PWM calibration sequencer testbench
// Runs start commands and sample ticks through the core, predicts each result
// with a behavioral model of the calibration sweep, and checks every result
// field by field. Random ticks follow a simple fan model (stop and start
// levels, jitter, noise, overtemperature) over many register settings.
// ---------------------------------------------------------------------------
module testbench;
    import fpcs_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 1350;

    typedef struct {
        logic [17:0] temp_limit;
        logic [7:0]  floor_lvl;
        logic [7:0]  ceil_lvl;
        logic [4:0]  win_len;
        logic [15:0] prec;
        phase_t      ph;
        logic [8:0]  lvl;
        int unsigned sw[16];
        int unsigned tw[16];
        int          ptr;
        logic [4:0]  run;
        bit          recorded;
        logic [15:0] mean_spd;
        logic [17:0] mean_tmp;
        logic [8:0]  stop_lvl;
        logic [7:0]  start_lvl;
        err_t        err;
        logic [15:0] slow_spd;
        logic [17:0] slow_tmp;
    } cal_state_t;

    typedef struct {
        logic [7:0]  pwm;
        logic [2:0]  ph;
        logic [1:0]  err;
        logic        fin;
        logic [8:0]  stop_lvl;
        logic [7:0]  start_lvl;
        logic [15:0] slow_spd;
        logic [17:0] slow_tmp;
    } cal_result_t;

    typedef struct {
        logic        op;
        logic [15:0] spd;
        logic [17:0] tmp;
    } sample_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_op = OP_START;
    logic [SPEED_W-1:0]    s_fan_speed = '0;
    logic [TEMP_W-1:0]     s_temperature = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [PWM_W-1:0]      m_pwm_drive;
    logic [2:0]            m_phase;
    logic [1:0]            m_error_code;
    logic                  m_finished;
    logic [PWM_W:0]        m_stop_pwm;
    logic [PWM_W-1:0]      m_start_pwm;
    logic [SPEED_W-1:0]    m_slowest_speed;
    logic [TEMP_W-1:0]     m_slowest_temp;

    sample_t     sample_q[$];
    cal_result_t result_q[$];
    cal_state_t  gen_state;
    cal_state_t  dut_state;
    cal_result_t gen_last;
    sample_t     next_sample;

    int  errors = 0;
    int  n_items = 0;
    int  n_checked = 0;
    int  n_done = 0;
    int  n_failed = 0;
    int  cycles = 0;
    int  gap = 0;
    int  stall = 0;
    bit  quiet = 1'b0;

    fan_pwm_calibration_sequencer_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_fan_speed(s_fan_speed), .s_temperature(s_temperature),
        .m_valid(m_valid), .m_ready(m_ready), .m_pwm_drive(m_pwm_drive),
        .m_phase(m_phase), .m_error_code(m_error_code), .m_finished(m_finished),
        .m_stop_pwm(m_stop_pwm), .m_start_pwm(m_start_pwm),
        .m_slowest_speed(m_slowest_speed), .m_slowest_temp(m_slowest_temp)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Calibration predictor
    // ------------------------------------------------------------------
    function automatic cal_state_t reset_state();
        cal_state_t s;
        s.temp_limit = 18'd85000;
        s.floor_lvl = 8'd0;
        s.ceil_lvl = 8'd255;
        s.win_len = 5'd15;
        s.prec = 16'd983;
        s.ph = PH_IDLE;
        s.lvl = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            s.sw[i] = 0;
            s.tw[i] = 0;
        end
        s.ptr = 0;
        s.run = '0;
        s.recorded = 1'b0;
        s.mean_spd = '0;
        s.mean_tmp = '0;
        s.stop_lvl = '0;
        s.start_lvl = '0;
        s.err = ERR_NONE;
        s.slow_spd = '0;
        s.slow_tmp = '0;
        return s;
    endfunction

    function automatic void clear_windows(inout cal_state_t s);
        for (int i = 0; i < WINDOW_MAX; i++) begin
            s.sw[i] = 0;
            s.tw[i] = 0;
        end
        s.ptr = 0;
    endfunction

    // Stable when the minimum is nonzero and the range is within precision.
    function automatic bit window_steady(input int unsigned w[16], input int n,
                                         input logic [15:0] prec);
        longint unsigned lo, hi;
        lo = w[0];
        hi = w[0];
        for (int i = 1; i < n; i++) begin
            if (w[i] < lo) lo = w[i];
            if (w[i] > hi) hi = w[i];
        end
        if (lo == 0) return 1'b0;
        return ((hi - lo) << 16) < (longint'(prec) * lo);
    endfunction

    function automatic longint unsigned window_mean(input int unsigned w[16], input int n);
        longint unsigned acc;
        acc = 0;
        for (int i = 0; i < n; i++) acc += w[i];
        return acc / n;
    endfunction

    function automatic void no_stop_found(inout cal_state_t s, input logic [15:0] spd,
                                          input logic [17:0] tmp);
        s.stop_lvl = {1'b0, s.floor_lvl} + 9'd1;
        s.slow_spd = spd;
        s.slow_tmp = tmp;
        s.ph = PH_SETTLE;
    endfunction

    function automatic void step_up(inout cal_state_t s);
        s.lvl = s.lvl + 9'd1;
        if (s.lvl >= {1'b0, s.ceil_lvl}) begin
            s.err = ERR_NO_START;
            s.ph = PH_ERROR;
        end else begin
            s.ph = PH_UP;
        end
    endfunction

    function automatic void apply_reg(inout cal_state_t s, input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_TEMP_LIMIT: s.temp_limit = val;
            CFG_PWM_FLOOR:  s.floor_lvl = val[7:0];
            CFG_PWM_CEIL:   s.ceil_lvl = val[7:0];
            CFG_WIN_LEN:    s.win_len = val[4:0];
            CFG_PRECISION:  s.prec = val[15:0];
            default: ;
        endcase
    endfunction

    function automatic cal_result_t advance(inout cal_state_t s, input logic op,
                                            input logic [15:0] spd, input logic [17:0] tmp);
        int n;
        cal_result_t r;
        n = (s.win_len < 1) ? 1 : (s.win_len > WINDOW_MAX) ? WINDOW_MAX : int'(s.win_len);
        if (op == OP_START) begin
            clear_windows(s);
            s.run = '0;
            s.recorded = 1'b0;
            s.mean_spd = '0;
            s.mean_tmp = '0;
            s.stop_lvl = '0;
            s.start_lvl = '0;
            s.err = ERR_NONE;
            s.slow_spd = '0;
            s.slow_tmp = '0;
            s.lvl = {1'b0, s.ceil_lvl};
            if (s.ceil_lvl > s.floor_lvl) s.ph = PH_DOWN;
            else no_stop_found(s, spd, tmp);
        end else if (s.ph == PH_DOWN) begin
            if (s.ptr >= n) s.ptr = 0;
            s.sw[s.ptr] = {16'd0, spd};
            s.tw[s.ptr] = {14'd0, tmp};
            s.ptr = (s.ptr + 1 >= n) ? 0 : s.ptr + 1;
            if (tmp >= s.temp_limit) begin
                s.err = ERR_OVERTEMP;
                s.ph = PH_ERROR;
            end else if (spd == 0) begin
                s.stop_lvl = s.lvl + 9'd1;
                s.slow_spd = s.recorded ? s.mean_spd : spd;
                s.slow_tmp = s.recorded ? s.mean_tmp : tmp;
                s.ph = PH_SETTLE;
            end else if (window_steady(s.sw, n, s.prec) && window_steady(s.tw, n, s.prec)) begin
                s.mean_spd = 16'(window_mean(s.sw, n));
                s.mean_tmp = 18'(window_mean(s.tw, n));
                s.recorded = 1'b1;
                clear_windows(s);
                s.lvl = {1'b0, s.lvl[7:0] - 8'd1};
                if (s.lvl <= {1'b0, s.floor_lvl}) no_stop_found(s, spd, tmp);
            end
        end else if (s.ph == PH_SETTLE) begin
            if (s.stop_lvl < {1'b0, s.ceil_lvl}) begin
                s.lvl = s.stop_lvl;
                s.ph = PH_UP;
            end else begin
                s.err = ERR_NO_START;
                s.ph = PH_ERROR;
            end
        end else if (s.ph == PH_UP) begin
            if (tmp >= s.temp_limit) begin
                s.err = ERR_OVERTEMP;
                s.ph = PH_ERROR;
            end else if (spd != 0) begin
                s.run = '0;
                s.ph = PH_VALIDATE;
            end else begin
                step_up(s);
            end
        end else if (s.ph == PH_VALIDATE) begin
            if (spd == 0) begin
                step_up(s);
            end else begin
                s.run = s.run + 5'd1;
                if (s.run >= n) begin
                    s.start_lvl = s.lvl[7:0];
                    s.ph = PH_DONE;
                end
            end
        end

        case (s.ph)
            PH_DOWN, PH_UP:        r.pwm = s.lvl[7:0];
            PH_VALIDATE, PH_DONE:  r.pwm = s.stop_lvl[7:0];
            PH_ERROR:              r.pwm = s.ceil_lvl;
            default:               r.pwm = 8'd0;
        endcase
        r.ph = s.ph;
        r.err = s.err;
        r.fin = (s.ph == PH_DONE || s.ph == PH_ERROR);
        r.stop_lvl = s.stop_lvl;
        r.start_lvl = s.start_lvl;
        r.slow_spd = s.slow_spd;
        r.slow_tmp = s.slow_tmp;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: feeds queued samples, with random bursts of idle cycles.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap <= 0;
        end else begin
            if (s_valid && s_ready)
                result_q.insert(result_q.size(),
                                advance(dut_state, s_op, s_fan_speed, s_temperature));
            if (!s_valid || s_ready) begin
                if (gap != 0) begin
                    gap <= gap - 1;
                    s_valid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    next_sample = sample_q[0];
                    sample_q.delete(0);
                    s_valid <= 1'b1;
                    s_op <= next_sample.op;
                    s_fan_speed <= next_sample.spd;
                    s_temperature <= next_sample.tmp;
                    if (!quiet && $urandom_range(0, 9) == 0) gap <= $urandom_range(1, 19);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transaction and stalls m_ready in bursts.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input longint e, input longint a);
        if (e != a) begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, e, a);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        cal_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: result with no expectation waiting", $time);
                    errors++;
                end else begin
                    want = result_q[0];
                    result_q.delete(0);
                    n_checked++;
                    check_field("pwm_drive", want.pwm, m_pwm_drive);
                    check_field("phase", want.ph, m_phase);
                    check_field("error_code", want.err, m_error_code);
                    check_field("finished", want.fin, m_finished);
                    check_field("stop_pwm", want.stop_lvl, m_stop_pwm);
                    check_field("start_pwm", want.start_lvl, m_start_pwm);
                    check_field("slowest_speed", want.slow_spd, m_slowest_speed);
                    check_field("slowest_temp", want.slow_tmp, m_slowest_temp);
                    if (want.ph == PH_DONE) n_done++;
                    if (want.ph == PH_ERROR) n_failed++;
                end
            end
            if (stall != 0) begin
                stall <= stall - 1;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall <= $urandom_range(1, 19);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic put(input logic op, input logic [15:0] spd, input logic [17:0] tmp);
        sample_t it;
        it.op = op;
        it.spd = spd;
        it.tmp = tmp;
        sample_q.insert(sample_q.size(), it);
        gen_last = advance(gen_state, op, spd, tmp);
        n_items++;
    endtask

    task automatic drain();
        while (sample_q.size() != 0 || s_valid || result_q.size() != 0) @(negedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        apply_reg(gen_state, idx, val);
        apply_reg(dut_state, idx, val);
    endtask

    // Writes all five registers; the block must be idle.
    task automatic configure(input int tl, input int fl, input int cl, input int wl,
                             input int pr);
        drain();
        set_reg(CFG_TEMP_LIMIT, CFG_DATA_W'(tl));
        set_reg(CFG_PWM_FLOOR, CFG_DATA_W'(fl));
        set_reg(CFG_PWM_CEIL, CFG_DATA_W'(cl));
        set_reg(CFG_WIN_LEN, CFG_DATA_W'(wl));
        set_reg(CFG_PRECISION, CFG_DATA_W'(pr));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // One calibration against a fan that stops below stop_at and restarts
    // at start_at, with jitter, occasional noise and overtemperature.
    task automatic calibrate(input int max_ticks);
        int stop_at, start_at, base, jit, tbase, tjit, r;
        bit running;
        logic [15:0] spd;
        logic [17:0] tmp;
        stop_at = $urandom_range(gen_state.floor_lvl, gen_state.ceil_lvl + 1);
        start_at = stop_at + $urandom_range(0, 2);
        base = $urandom_range(1000, 60000);
        jit = base / 64;
        tbase = $urandom_range(20000, 60000);
        tjit = tbase / 256;
        put(OP_START, 16'($urandom_range(0, 65535)), 18'($urandom_range(0, 262143)));
        for (int t = 0; t < max_ticks; t++) begin
            if (n_items >= RANDOM_ITEMS + 40) break;
            if (gen_last.fin) begin
                if ($urandom_range(0, 2) == 0) put(OP_TICK, 16'($urandom), 18'($urandom));
                break;
            end
            if (gen_last.ph == PH_UP) running = gen_last.pwm >= start_at;
            else running = gen_last.pwm >= stop_at;
            spd = running ? 16'(base + $urandom_range(0, jit)) : 16'd0;
            tmp = 18'(tbase + $urandom_range(0, tjit));
            r = $urandom_range(0, 199);
            if (r < 4) spd = 16'($urandom_range(0, 65535));
            else if (r < 7) spd = 16'd0;
            else if (r == 7) tmp = 18'($urandom_range(0, 262143));
            if (r == 8) put(OP_START, spd, tmp);
            else put(OP_TICK, spd, tmp);
        end
    endtask

    initial begin
        int fl, cl, wl, pr, tl, n, r;
        gen_state = reset_state();
        dut_state = reset_state();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: ticks while idle, extremes at the reset settings,
        // overtemperature, a stop with no recorded level and an empty sweep up.
        put(OP_TICK, 16'hFFFF, 18'h3FFFF);
        put(OP_START, 16'd0, 18'd0);
        put(OP_TICK, 16'hFFFF, 18'h3FFFF);
        put(OP_TICK, 16'd1, 18'd1);
        put(OP_START, 16'hFFFF, 18'h3FFFF);
        put(OP_TICK, 16'd0, 18'd0);
        put(OP_TICK, 16'd0, 18'd0);
        put(OP_TICK, 16'd500, 18'd500);
        // Ceiling not above floor: no stop found at once.
        configure(18'h3FFFF, 0, 0, 0, 16'hFFFF);
        put(OP_START, 16'd1234, 18'd4321);
        put(OP_TICK, 16'd0, 18'd0);
        // Short sweep down to the floor, then a start found but lost at the ceiling.
        configure(18'h3FFFF, 0, 3, 1, 16'hFFFF);
        put(OP_START, 16'd0, 18'd0);
        put(OP_TICK, 16'd500, 18'd1000);
        put(OP_TICK, 16'd600, 18'd1000);
        put(OP_TICK, 16'd700, 18'd1000);
        put(OP_TICK, 16'd0, 18'd0);
        put(OP_TICK, 16'd0, 18'd1000);
        put(OP_TICK, 16'd700, 18'd1000);
        put(OP_TICK, 16'd0, 18'd1000);
        put(OP_TICK, 16'd800, 18'd1000);
        put(OP_TICK, 16'd800, 18'd1000);
        // Zero temperature limit with ceiling equal to floor: no sweep, no start found.
        configure(0, 255, 255, 31, 0);
        put(OP_START, 16'd9, 18'd9);
        put(OP_TICK, 16'd9, 18'd9);
        drain();

        // Sweep down from the top with a one-sample window.
        configure(85000, 0, 255, 1, 16'hFFFF);
        calibrate(1200);
        drain();

        // Random settings, mostly short sweeps and short windows.
        while (n_items < RANDOM_ITEMS + 40) begin
            if (n_items > RANDOM_ITEMS - 200) quiet = 1'b1;
            fl = $urandom_range(0, 250);
            cl = fl + $urandom_range(0, 5);
            r = $urandom_range(0, 7);
            if (r == 0) fl = 0;
            else if (r == 1) cl = 255;
            else if (r == 2) cl = fl;
            if (cl > 255) cl = 255;
            r = $urandom_range(0, 9);
            wl = (r == 0) ? 0 : (r == 1) ? 16 : (r == 2) ? 31 : $urandom_range(1, 4);
            if (wl > 4 && cl - fl > 2) cl = fl + 2;
            r = $urandom_range(0, 9);
            pr = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(1500, 65535);
            r = $urandom_range(0, 9);
            tl = (r == 0) ? 0 : (r == 1) ? 262143 : 85000;
            configure(tl, fl, cl, wl, pr);
            n = (wl < 1) ? 1 : (wl > 16) ? 16 : wl;
            repeat ($urandom_range(1, 3)) calibrate((cl - fl + 3) * (n + 2) * 2 + 20);
            drain();
        end

        drain();
        repeat (100) @(posedge aclk);
        $display("Sent %0d transactions and checked %0d results;", n_items, n_checked);
        $display("%0d results showed a finished calibration, %0d an error.", n_done, n_failed);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
